// File: hw/rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg: shared definitions for the cubic Bezier subdivider
// Parameter defaults, register reset values and the sequencer state codes.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // Default parameter values
  localparam int DEF_MAX_DEPTH   = 6;
  localparam int DEF_COORD_WIDTH = 16;
  localparam int DEF_FRAC_BITS   = 4;

  // Register reset value and pixel field width
  localparam logic [7:0] FLAT_THRESHOLD_RESET = 8'd5;
  localparam int         PIX_W                = 12;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EVAL    = 4'b0010,
    ST_SPLIT_Y = 4'b0100,
    ST_LOAD    = 4'b1000
  } state_t;

endpackage

// File: hw/rtl/cbs_split_unit.sv
// ----------------------------------------------------------------------------
// cbs_split_unit: de Casteljau halving of one axis
// Splits four control coordinates at t=1/2 with floor midpoints; shared
// between the x and y axes by the sequencer.
// ----------------------------------------------------------------------------
module cbs_split_unit #(
  parameter int W = cbs_pkg::DEF_COORD_WIDTH
) (
  input  logic signed [W-1:0] c0,
  input  logic signed [W-1:0] c1,
  input  logic signed [W-1:0] c2,
  input  logic signed [W-1:0] c3,
  output logic signed [W-1:0] s1,
  output logic signed [W-1:0] s2,
  output logic signed [W-1:0] m,
  output logic signed [W-1:0] t1,
  output logic signed [W-1:0] t2
);

  // Floor of the average: widen, add, drop the low bit
  function automatic logic signed [W-1:0] mid(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    return s[W:1];
  endfunction

  logic signed [W-1:0] t;

  // Build the midpoint tree
  always_comb begin
    t  = mid(c1, c2);
    s1 = mid(c0, c1);
    s2 = mid(s1, t);
    t2 = mid(c2, c3);
    t1 = mid(t2, t);
    m  = mid(s2, t1);
  end

endmodule

// File: hw/rtl/cubic_bezier_subdivider_core.sv
// Busy: a curve that ends in N segments (1 to 2**MAX_DEPTH) keeps busy high through
//   a check per piece, a second (y) step per split and a stack read per pop.
// Throughput: one curve at a time; start is taken again in the cycle that shows the
//   last segment. Segment beats cannot be stalled by the receiver.
// Reset: synchronous; clears the sequencer, strobe and stack count, and sets
//   flat_threshold to 5. Stack contents are not cleared.
// ----------------------------------------------------------------------------
// cubic_bezier_subdivider_core: adaptive cubic Bezier to line segments
// Depth-first halving with a small LIFO of pending lower halves; each flat or
// depth-capped piece is emitted with rounded, saturated pixel end points.
// ----------------------------------------------------------------------------
module cubic_bezier_subdivider_core #(
  parameter int MAX_DEPTH   = cbs_pkg::DEF_MAX_DEPTH,
  parameter int COORD_WIDTH = cbs_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = cbs_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] p0_x,
  input  logic [15:0] p0_y,
  input  logic [15:0] p1_x,
  input  logic [15:0] p1_y,
  input  logic [15:0] p2_x,
  input  logic [15:0] p2_y,
  input  logic [15:0] p3_x,
  input  logic [15:0] p3_y,
  input  logic [3:0]  raster_op,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        seg_valid,
  output logic [11:0] seg_x_start,
  output logic [11:0] seg_y_start,
  output logic [11:0] seg_x_end,
  output logic [11:0] seg_y_end,
  output logic [3:0]  seg_raster_op,
  output logic        forced,
  output logic        last
);
  import cbs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int LVW  = $clog2(MAX_DEPTH + 1);
  localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int EW   = 8 * CW + LVW;
  localparam int CMPW = (CW + 1 > 8 + FRAC_BITS) ? CW + 1 : 8 + FRAC_BITS;
  localparam int PW   = (CW + 1 > PIX_W + 1) ? CW + 1 : PIX_W + 1;

  localparam logic signed [PW-1:0] HALF    = PW'((2 ** FRAC_BITS) >> 1);
  localparam logic signed [PW-1:0] PIX_MAX = PW'((2 ** (PIX_W - 1)) - 1);
  localparam logic signed [PW-1:0] PIX_MIN = -PW'(2 ** (PIX_W - 1));
  localparam logic [LVW-1:0]       LVL_CAP = LVW'(MAX_DEPTH);

  // Round to whole pixels (floor after adding half) and saturate
  function automatic logic [PIX_W-1:0] to_pixel(input logic signed [CW-1:0] v);
    logic signed [PW-1:0] s;
    logic signed [PW-1:0] r;
    s = PW'(v) + HALF;
    r = s >>> FRAC_BITS;
    if (r > PIX_MAX) begin
      r = PIX_MAX;
    end else if (r < PIX_MIN) begin
      r = PIX_MIN;
    end
    return r[PIX_W-1:0];
  endfunction

  state_t state;
  logic [7:0] flat_threshold;
  logic signed [CW-1:0] cur_x [4];
  logic signed [CW-1:0] cur_y [4];
  logic signed [CW-1:0] lo_x  [4];
  logic [LVW-1:0] level;
  logic [LVW-1:0] top;
  logic [LVW-1:0] top_m1;
  logic [3:0] op;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] stack_mem [MAX_DEPTH];

  // Shared split unit: x during the check cycle, y in the following one
  logic signed [CW-1:0] u_c0, u_c1, u_c2, u_c3;
  logic signed [CW-1:0] u_s1, u_s2, u_m, u_t1, u_t2;

  always_comb begin
    if (state == ST_EVAL) begin
      u_c0 = cur_x[0];
      u_c1 = cur_x[1];
      u_c2 = cur_x[2];
      u_c3 = cur_x[3];
    end else begin
      u_c0 = cur_y[0];
      u_c1 = cur_y[1];
      u_c2 = cur_y[2];
      u_c3 = cur_y[3];
    end
  end

  cbs_split_unit #(
    .W (CW)
  ) u_split (
    .c0 (u_c0),
    .c1 (u_c1),
    .c2 (u_c2),
    .c3 (u_c3),
    .s1 (u_s1),
    .s2 (u_s2),
    .m  (u_m),
    .t1 (u_t1),
    .t2 (u_t2)
  );

  // Flatness test on the end points of the current piece
  logic signed [CW:0] dx, dy;
  logic [CW:0] adx, ady;
  logic [CMPW-1:0] lim;
  logic flat, emit;

  always_comb begin
    dx   = {cur_x[0][CW-1], cur_x[0]} - {cur_x[3][CW-1], cur_x[3]};
    dy   = {cur_y[0][CW-1], cur_y[0]} - {cur_y[3][CW-1], cur_y[3]};
    adx  = dx[CW] ? -dx : dx;
    ady  = dy[CW] ? -dy : dy;
    lim  = CMPW'(flat_threshold) << FRAC_BITS;
    flat = (CMPW'(adx) < lim) && (CMPW'(ady) < lim);
    emit = flat || (level >= LVL_CAP);
  end

  assign top_m1 = top - 1'b1;
  assign busy   = (state != ST_IDLE);

  // Sequencer, configuration register and segment beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      flat_threshold <= FLAT_THRESHOLD_RESET;
      seg_valid      <= 1'b0;
      top            <= '0;
    end else begin
      seg_valid <= 1'b0;
      if (cfg_we) begin
        flat_threshold <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur_x[0] <= p0_x[CW-1:0];
            cur_x[1] <= p1_x[CW-1:0];
            cur_x[2] <= p2_x[CW-1:0];
            cur_x[3] <= p3_x[CW-1:0];
            cur_y[0] <= p0_y[CW-1:0];
            cur_y[1] <= p1_y[CW-1:0];
            cur_y[2] <= p2_y[CW-1:0];
            cur_y[3] <= p3_y[CW-1:0];
            level    <= '0;
            top      <= '0;
            op       <= raster_op;
            state    <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (emit) begin
            seg_valid     <= 1'b1;
            seg_x_start   <= to_pixel(cur_x[0]);
            seg_y_start   <= to_pixel(cur_y[0]);
            seg_x_end     <= to_pixel(cur_x[3]);
            seg_y_end     <= to_pixel(cur_y[3]);
            seg_raster_op <= op;
            forced        <= ~flat;
            last          <= (top == '0);
            if (top == '0) begin
              state <= ST_IDLE;
            end else begin
              top   <= top_m1;
              state <= ST_LOAD;
            end
          end else begin
            // Keep the upper half as the next piece; hold the lower x half
            lo_x[0]  <= cur_x[0];
            lo_x[1]  <= u_s1;
            lo_x[2]  <= u_s2;
            lo_x[3]  <= u_m;
            cur_x[0] <= u_m;
            cur_x[1] <= u_t1;
            cur_x[2] <= u_t2;
            state    <= ST_SPLIT_Y;
          end
        end
        ST_SPLIT_Y: begin
          cur_y[0] <= u_m;
          cur_y[1] <= u_t1;
          cur_y[2] <= u_t2;
          level    <= level + 1'b1;
          top      <= top + 1'b1;
          state    <= ST_EVAL;
        end
        ST_LOAD: begin
          for (int i = 0; i < 4; i++) begin
            cur_x[i] <= rd_data[LVW + 4 * CW + i * CW +: CW];
            cur_y[i] <= rd_data[LVW + i * CW +: CW];
          end
          level <= rd_data[LVW-1:0];
          state <= ST_EVAL;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Stack of pending lower halves: push during the y split, read on pop
  always_ff @(posedge clk) begin
    if (state == ST_SPLIT_Y) begin
      stack_mem[top[AW-1:0]] <= {lo_x[3], lo_x[2], lo_x[1], lo_x[0],
                                 u_m, u_s2, u_s1, cur_y[0], level + 1'b1};
    end
    if (state == ST_EVAL && emit && top != '0) begin
      rd_data <= stack_mem[top_m1[AW-1:0]];
    end
  end

endmodule

// File: hw/rtl/cbs_checker.sv
// ----------------------------------------------------------------------------
// cbs_checker: port-level checks for the cubic Bezier subdivider
// Watches the command handshake and segment beats; bound to the top level.
// ----------------------------------------------------------------------------
module cbs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic seg_valid,
  input logic last
);

  // An accepted command starts work
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted command");

  // Every segment beat comes out of active work
  a_beat_from_work: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> $past(busy))
    else $error("segment beat without a curve in progress");

  // The final beat ends the curve, any other keeps it going
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> (last == !busy))
    else $error("last flag and busy disagree");

  // Work only ends with the final beat
  a_end_needs_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (seg_valid && last))
    else $error("busy dropped without a final segment");

endmodule

bind cubic_bezier_subdivider_core cbs_checker u_cbs_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .seg_valid (seg_valid),
  .last      (last)
);

// File: tb/cubic_bezier_subdivider_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_subdivider_core_tb: self-checking bench for the curve splitter
// Feeds cubic curves through the start/busy port and predicts every segment
// with a local halving stack. Checks each segment beat in order. Runs several
// flatness thresholds, including zero and the 8-bit maximum, with random gaps.
// ----------------------------------------------------------------------------
module cubic_bezier_subdivider_core_tb;
  import cbs_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_SEGS    = 1 << DEF_MAX_DEPTH;

  // One curve: four points per axis, point 0 in the low bits
  typedef struct packed {
    logic [63:0] xs;
    logic [63:0] ys;
    logic [3:0]  op;
  } curve_t;

  // One line segment as seen on the result ports
  typedef struct packed {
    logic [11:0] xs;
    logic [11:0] ys;
    logic [11:0] xe;
    logic [11:0] ye;
    logic [3:0]  op;
    logic        forced;
    logic        last;
  } seg_t;

  // A pending piece of the curve and its split depth
  typedef struct packed {
    logic [63:0] xs;
    logic [63:0] ys;
    logic [2:0]  depth;
  } piece_t;

  // --------------------------------------------------------------------------
  // Segment scoreboard: predicts the segments of each curve, checks beats
  // --------------------------------------------------------------------------
  class segment_scoreboard;
    seg_t       expected_segs[$];
    logic [7:0] threshold = FLAT_THRESHOLD_RESET;
    int         errors = 0;
    int         curves = 0;
    int         segs = 0;
    int         capped = 0;
    int         thr_writes = 0;

    function int pending();
      return expected_segs.size();
    endfunction

    function void set_threshold(logic [7:0] value);
      threshold = value;
      thr_writes++;
    endfunction

    // Floor of the mean of two coordinates
    function logic signed [15:0] halve(logic signed [15:0] a, logic signed [15:0] b);
      logic signed [16:0] s;
      s = $signed({a[15], a}) + $signed({b[15], b});
      return s[16:1];
    endfunction

    // Round to whole pixels and clamp to the 12-bit range
    function logic [11:0] to_pixel(logic signed [15:0] v);
      logic signed [16:0] s;
      logic signed [12:0] r;
      s = $signed({v[15], v}) + 17'sd8;
      r = 13'(s >>> DEF_FRAC_BITS);
      if (r > 13'sd2047) return 12'h7ff;
      if (r < -13'sd2048) return 12'h800;
      return r[11:0];
    endfunction

    // Distance between the end points of one axis
    function logic signed [16:0] span(logic [63:0] c);
      logic signed [16:0] d;
      d = $signed({c[15], c[15:0]}) - $signed({c[63], c[63:48]});
      return (d < 0) ? -d : d;
    endfunction

    // De Casteljau split at one half
    function void split_axis(logic [63:0] c, output logic [63:0] lo, output logic [63:0] hi);
      logic signed [15:0] c0, c1, c2, c3, t, s1, s2, t1, t2, m;
      c0 = c[15:0];
      c1 = c[31:16];
      c2 = c[47:32];
      c3 = c[63:48];
      t  = halve(c1, c2);
      s1 = halve(c0, c1);
      s2 = halve(s1, t);
      t2 = halve(c2, c3);
      t1 = halve(t2, t);
      m  = halve(s2, t1);
      lo = {m, s2, s1, c0};
      hi = {c3, t2, t1, m};
    endfunction

    // Walk the curve depth first, upper half first, and queue its segments
    function void note_curve(curve_t c);
      piece_t             pile[$];
      piece_t             p;
      logic [63:0]        xl, xh, yl, yh;
      logic signed [16:0] lim;
      bit                 flat;
      seg_t               s;
      int                 n;
      n   = 0;
      lim = $signed({5'd0, threshold, 4'd0});
      pile.push_back({c.xs, c.ys, 3'd0});
      curves++;
      while (pile.size() > 0 && n < MAX_SEGS) begin
        p    = pile.pop_back();
        flat = (span(p.xs) < lim) && (span(p.ys) < lim);
        if (flat || p.depth >= DEF_MAX_DEPTH) begin
          s.xs     = to_pixel(p.xs[15:0]);
          s.ys     = to_pixel(p.ys[15:0]);
          s.xe     = to_pixel(p.xs[63:48]);
          s.ye     = to_pixel(p.ys[63:48]);
          s.op     = c.op;
          s.forced = !flat;
          s.last   = (pile.size() == 0);
          expected_segs.push_back(s);
          n++;
          segs++;
          if (!flat) capped++;
        end else begin
          split_axis(p.xs, xl, xh);
          split_axis(p.ys, yl, yh);
          pile.push_back({xl, yl, p.depth + 3'd1});
          pile.push_back({xh, yh, p.depth + 3'd1});
        end
      end
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void check_segment(seg_t got);
      seg_t want;
      if (expected_segs.size() == 0) begin
        errors++;
        $error("segment beat with nothing expected: 0x%0h", got);
        return;
      end
      want = expected_segs.pop_front();
      compare("seg_x_start", want.xs, got.xs);
      compare("seg_y_start", want.ys, got.ys);
      compare("seg_x_end", want.xe, got.xe);
      compare("seg_y_end", want.ye, got.ye);
      compare("seg_raster_op", want.op, got.op);
      compare("forced", want.forced, got.forced);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] p0_x = '0, p0_y = '0, p1_x = '0, p1_y = '0;
  logic [15:0] p2_x = '0, p2_y = '0, p3_x = '0, p3_y = '0;
  logic [3:0]  raster_op = '0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        seg_valid;
  logic [11:0] seg_x_start, seg_y_start, seg_x_end, seg_y_end;
  logic [3:0]  seg_raster_op;
  logic        forced;
  logic        last;

  segment_scoreboard sb = new();
  bit                idle_on = 1'b1;
  int unsigned       quiet_cycles = 0;

  cubic_bezier_subdivider_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .p0_x         (p0_x),
    .p0_y         (p0_y),
    .p1_x         (p1_x),
    .p1_y         (p1_y),
    .p2_x         (p2_x),
    .p2_y         (p2_y),
    .p3_x         (p3_x),
    .p3_y         (p3_y),
    .raster_op    (raster_op),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .seg_valid    (seg_valid),
    .seg_x_start  (seg_x_start),
    .seg_y_start  (seg_y_start),
    .seg_x_end    (seg_x_end),
    .seg_y_end    (seg_y_end),
    .seg_raster_op(seg_raster_op),
    .forced       (forced),
    .last         (last)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: check segment beats, track register writes, note accepted curves
  always @(posedge clk) begin
    if (!rst) begin
      if (seg_valid)
        sb.check_segment({seg_x_start, seg_y_start, seg_x_end, seg_y_end,
                          seg_raster_op, forced, last});
      if (cfg_we)
        sb.set_threshold(cfg_wdata);
      if (start && !busy)
        sb.note_curve({p3_x, p2_x, p1_x, p0_x, p3_y, p2_y, p1_y, p0_y, raster_op});
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || seg_valid || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic curve_t mk(int x0, int y0, int x1, int y1, int x2, int y2,
                                int x3, int y3, int op);
    curve_t c;
    c.xs = {16'(x3), 16'(x2), 16'(x1), 16'(x0)};
    c.ys = {16'(y3), 16'(y2), 16'(y1), 16'(y0)};
    c.op = 4'(op);
    return c;
  endfunction

  // Mostly local curves of random size, some raw noise, points and extremes
  function automatic curve_t random_curve();
    curve_t      c;
    logic [15:0] pts[8];
    int          kind, scale, cx, cy, k;
    kind = $urandom_range(0, 9);
    cx   = int'($urandom_range(0, 65535)) - 32768;
    cy   = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 3))
      0:       scale = 3;
      1:       scale = 40;
      2:       scale = 300;
      default: scale = 2500;
    endcase
    for (k = 0; k < 8; k++) begin
      case (kind)
        0, 1: pts[k] = 16'($urandom);
        8:    pts[k] = 16'((k % 2) ? cy : cx);
        9: begin
          case ($urandom_range(0, 4))
            0:       pts[k] = 16'h8000;
            1:       pts[k] = 16'h7fff;
            2:       pts[k] = 16'h0000;
            3:       pts[k] = 16'hffff;
            default: pts[k] = 16'($urandom);
          endcase
        end
        default: pts[k] = 16'(((k % 2) ? cy : cx) + int'($urandom_range(0, 2 * scale)) - scale);
      endcase
    end
    c.xs = {pts[6], pts[4], pts[2], pts[0]};
    c.ys = {pts[7], pts[5], pts[3], pts[1]};
    c.op = 4'($urandom);
    return c;
  endfunction

  // Present one curve and hold it until the block takes it
  task automatic send_curve(input curve_t c);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < 35) gap++;
      if ($urandom_range(15) == 0) gap += $urandom_range(1, 260);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    p0_x      <= c.xs[15:0];
    p1_x      <= c.xs[31:16];
    p2_x      <= c.xs[47:32];
    p3_x      <= c.xs[63:48];
    p0_y      <= c.ys[15:0];
    p1_y      <= c.ys[31:16];
    p2_y      <= c.ys[47:32];
    p3_y      <= c.ys[63:48];
    raster_op <= c.op;
    do @(posedge clk); while (busy);
  endtask

  // Drain outstanding segments, then write the threshold while idle
  task automatic write_threshold(input logic [7:0] value);
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0 || busy);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [7:0] phase_thr[5];
    int         ph;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed curves at the reset threshold
    send_curve(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_curve(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 15));
    send_curve(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0));
    send_curve(mk(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767, 10));
    send_curve(mk(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 5));
    // Rounding just below and at the half pixel, both signs
    send_curve(mk(7, 8, 0, 0, 0, 0, -8, -9, 1));
    // Flatness edge: one below the limit, then exactly at it on each axis
    send_curve(mk(0, 0, 20, 0, 60, 0, 79, 0, 2));
    send_curve(mk(0, 0, 20, 0, 60, 0, 80, 0, 3));
    send_curve(mk(0, 0, 0, 20, 0, 60, 0, 80, 4));
    // Odd negative sums exercise the floor in halving
    send_curve(mk(-1, -3, -5, -7, -9, -11, -13, -163, 6));
    // Closed loop: end points coincide, so flat at once
    send_curve(mk(0, 0, 3200, 3200, -3200, 3200, 0, 0, 7));
    send_curve(mk(-1600, -800, 1600, -1600, -1600, 1600, 1600, 800, 8));
    send_curve(mk(32760, 32767, 32767, -32768, -32768, 32767, 32759, -32761, 9));
    send_curve(mk(21845, -21846, -21846, 21845, 21845, -21846, -21846, 21845, 12));

    // Threshold zero: nothing is ever flat
    write_threshold(8'd0);
    send_curve(mk(0, 0, 0, 0, 0, 0, 0, 0, 13));
    send_curve(mk(1, 2, 3, 4, 5, 6, 7, 8, 14));

    // Largest threshold
    write_threshold(8'd255);
    send_curve(mk(0, 0, 0, 0, 0, 0, 4079, -4079, 11));
    send_curve(mk(0, 0, 0, 0, 0, 0, 4080, 0, 3));
    send_curve(mk(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768, 15));

    // Smallest nonzero threshold
    write_threshold(8'd1);
    send_curve(mk(0, 0, 5, 5, 10, 10, 15, 15, 11));
    send_curve(mk(0, 0, 5, 5, 10, 10, 16, 16, 2));

    // Random phases; the third runs back to back with no gaps
    phase_thr[0] = 8'd1;
    phase_thr[1] = 8'd255;
    phase_thr[2] = 8'($urandom_range(1, 255));
    phase_thr[3] = 8'($urandom_range(2, 40));
    phase_thr[4] = FLAT_THRESHOLD_RESET;
    for (ph = 0; ph < 5; ph++) begin
      write_threshold(phase_thr[ph]);
      idle_on = (ph != 2);
      repeat (70) send_curve(random_curve());
    end

    // Drain and let any stray beats show up
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Ran %0d curves through %0d threshold writes.", sb.curves, sb.thr_writes);
    $display("Checked %0d segments, %0d of them cut off at the depth cap.",
             sb.segs, sb.capped);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/cbs_pkg.sv
hw/rtl/cbs_split_unit.sv
hw/rtl/cubic_bezier_subdivider_core.sv
hw/rtl/cbs_checker.sv
tb/cubic_bezier_subdivider_core_tb.sv
